FILE: sv/tccm_pkg.sv
// Shared types, fixed-point constants and the arctangent table for the
// tilt-compensated compass heading core. No dependencies.
package tccm_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN = 24;

    localparam logic [1:0] REG_BIAS_X = 2'd0;
    localparam logic [1:0] REG_BIAS_Y = 2'd1;
    localparam logic [1:0] REG_BIAS_Z = 2'd2;

    localparam logic signed [20:0] ANG_SCALE    = 21'sd291924;
    localparam logic signed [35:0] PI_Q30       = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30  = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q30   = 36'sd6746518852;
    localparam logic signed [31:0] GAIN_INV_Q30 = 32'sd652032874;
    localparam logic signed [28:0] DEG64_Q16    = 29'sd240315917;
    localparam logic signed [18:0] HEAD_OFFSET  = 19'sd11520;
    localparam logic signed [18:0] HEAD_MAX     = 19'sd23040;

    // Per-transaction side data that rides along the whole pipeline.
    typedef struct packed {
        logic               vld;
        logic               err;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
    } t_side;

    // Rotation-mode CORDIC state (sine and cosine).
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [35:0] th;
        logic               neg;
    } t_rot;

    // Vectoring-mode CORDIC state (atan2).
    typedef struct packed {
        logic signed [51:0] x;
        logic signed [51:0] y;
        logic signed [35:0] z;
        logic               zero;
    } t_vec;

    function automatic logic signed [35:0] atan_q30(input logic [4:0] idx);
        logic signed [35:0] v;
        case (idx)
            5'd0:    v = 36'sd843314856;
            5'd1:    v = 36'sd497837829;
            5'd2:    v = 36'sd263043836;
            5'd3:    v = 36'sd133525158;
            5'd4:    v = 36'sd67021686;
            5'd5:    v = 36'sd33543515;
            5'd6:    v = 36'sd16775850;
            5'd7:    v = 36'sd8388437;
            5'd8:    v = 36'sd4194282;
            5'd9:    v = 36'sd2097149;
            5'd10:   v = 36'sd1048575;
            5'd11:   v = 36'sd524287;
            5'd12:   v = 36'sd262143;
            5'd13:   v = 36'sd131071;
            5'd14:   v = 36'sd65535;
            5'd15:   v = 36'sd32767;
            5'd16:   v = 36'sd16383;
            5'd17:   v = 36'sd8191;
            5'd18:   v = 36'sd4095;
            5'd19:   v = 36'sd2047;
            5'd20:   v = 36'sd1023;
            5'd21:   v = 36'sd511;
            5'd22:   v = 36'sd255;
            5'd23:   v = 36'sd127;
            default: v = 36'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/tccm_rot_stage.sv
// One registered rotation-mode CORDIC iteration for sine and cosine.
// Depends on tccm_pkg.
module tccm_rot_stage #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  tccm_pkg::t_rot i_d,
    output tccm_pkg::t_rot o_q
);
    tccm_pkg::t_rot r_q;
    tccm_pkg::t_rot n_q;
    logic signed [35:0] w_atan;

    assign w_atan = tccm_pkg::atan_q30(5'(STEP));

    always_comb begin
        n_q = i_d;
        if (!i_d.th[35]) begin
            n_q.x  = i_d.x - (i_d.y >>> STEP);
            n_q.y  = i_d.y + (i_d.x >>> STEP);
            n_q.th = i_d.th - w_atan;
        end else begin
            n_q.x  = i_d.x + (i_d.y >>> STEP);
            n_q.y  = i_d.y - (i_d.x >>> STEP);
            n_q.th = i_d.th + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

FILE: sv/tccm_vec_stage.sv
// One registered vectoring-mode CORDIC iteration for atan2.
// Depends on tccm_pkg.
module tccm_vec_stage #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  tccm_pkg::t_vec i_d,
    output tccm_pkg::t_vec o_q
);
    tccm_pkg::t_vec r_q;
    tccm_pkg::t_vec n_q;
    logic signed [35:0] w_atan;

    assign w_atan = tccm_pkg::atan_q30(5'(STEP));

    always_comb begin
        n_q = i_d;
        if (!i_d.y[51]) begin
            n_q.x = i_d.x + (i_d.y >>> STEP);
            n_q.y = i_d.y - (i_d.x >>> STEP);
            n_q.z = i_d.z + w_atan;
        end else begin
            n_q.x = i_d.x - (i_d.y >>> STEP);
            n_q.y = i_d.y + (i_d.x >>> STEP);
            n_q.z = i_d.z - w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

FILE: sv/tccm_head.sv
// Converts the Q30 radian angle to a clamped heading in 1/64 degree.
// Two register stages: split partial products, then sum, round and clamp. Uses tccm_pkg.
module tccm_head (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [35:0] i_ang,
    input  logic               i_zero,
    output logic [14:0]        o_heading
);
    logic signed [35:0] w_ang;
    logic signed [47:0] n_p_hi;
    logic signed [47:0] n_p_lo;
    logic signed [47:0] r_p_hi;
    logic signed [47:0] r_p_lo;
    logic signed [63:0] w_sum;
    logic signed [18:0] w_h;
    logic [14:0]        n_heading;
    logic [14:0]        r_heading;

    // The angle is split into a signed upper part and an unsigned 17-bit lower part.
    always_comb begin
        w_ang  = i_zero ? 36'sd0 : i_ang;
        n_p_hi = $signed(w_ang[35:17]) * tccm_pkg::DEG64_Q16;
        n_p_lo = $signed({1'b0, w_ang[16:0]}) * tccm_pkg::DEG64_Q16;
    end

    always_comb begin
        w_sum = (64'(r_p_hi) <<< 17) + 64'(r_p_lo) + (64'sd1 <<< 45);
        w_h   = $signed(w_sum[63:46]) + tccm_pkg::HEAD_OFFSET;
        if (w_h[18]) begin
            n_heading = 15'd0;
        end else if (w_h > tccm_pkg::HEAD_MAX) begin
            n_heading = 15'(tccm_pkg::HEAD_MAX);
        end else begin
            n_heading = w_h[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_hi    <= n_p_hi;
            r_p_lo    <= n_p_lo;
            r_heading <= n_heading;
        end
    end

    assign o_heading = r_heading;
endmodule

FILE: sv/tilt_compensated_compass_heading_core.sv
// Tilt-compensated compass heading core, top level.
// The CORDIC chains run N = min(CORDIC_STEPS, 24) iterations;
// one transaction is accepted every cycle while o_stall is low, set by the fully pipelined CORDIC chains.
// The whole pipeline advances together; a stall at the output while o_valid is high holds every stage.
// Synchronous active-low reset clears all valid bits and the bias registers to zero.
module tilt_compensated_compass_heading_core #(
    parameter int CORDIC_STEPS = tccm_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_mag_x,
    input  logic signed [15:0] i_mag_y,
    input  logic signed [15:0] i_mag_z,
    input  logic               i_read_failed,
    input  logic signed [14:0] i_pitch_angle,
    input  logic signed [14:0] i_roll_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [14:0]        o_heading,
    output logic signed [15:0] o_corrected_x,
    output logic signed [15:0] o_corrected_y,
    output logic signed [15:0] o_corrected_z,
    output logic               o_error_flag
);
    localparam int N = (CORDIC_STEPS > tccm_pkg::ATAN_LEN) ? tccm_pkg::ATAN_LEN : CORDIC_STEPS;
    localparam int L = 2 * N + 8;

    logic [15:0] r_bias_x;
    logic [15:0] r_bias_y;
    logic [15:0] r_bias_z;
    logic        w_en;

    tccm_pkg::t_side r_sd [0:L-1];
    tccm_pkg::t_side n_sd0;

    logic signed [35:0] r_th_p;
    logic signed [35:0] r_th_r;
    tccm_pkg::t_rot     r_rp;
    tccm_pkg::t_rot     r_rr;
    tccm_pkg::t_rot     w_p [0:N];
    tccm_pkg::t_rot     w_r [0:N];

    logic signed [31:0] w_sp, w_cp, w_sr, w_cr;
    logic signed [63:0] w_ssp_full, w_csr_full;
    logic signed [33:0] r_ssp, r_csr;
    logic signed [31:0] r_cp, r_sr, r_cr;
    logic signed [49:0] n_m0, n_m1, n_m2, n_m3, n_m4;
    logic signed [49:0] r_m0, r_m1, r_m2, r_m3, r_m4;
    logic signed [51:0] r_hy, r_hx;
    tccm_pkg::t_vec     n_v0;
    tccm_pkg::t_vec     r_v0;
    tccm_pkg::t_vec     w_v [0:N];
    logic [14:0]        w_heading;

    function automatic tccm_pkg::t_rot f_reduce(input logic signed [35:0] th_in);
        tccm_pkg::t_rot v;
        logic signed [35:0] th;
        th = th_in;
        v.neg = 1'b0;
        if (th > tccm_pkg::PI_Q30) begin
            th = th - tccm_pkg::TWO_PI_Q30;
        end else if (th < -tccm_pkg::PI_Q30) begin
            th = th + tccm_pkg::TWO_PI_Q30;
        end
        // Fold into the half plane where the CORDIC converges; the sign flips back later.
        if (th > tccm_pkg::HALF_PI_Q30) begin
            th = th - tccm_pkg::PI_Q30;
            v.neg = 1'b1;
        end else if (th < -tccm_pkg::HALF_PI_Q30) begin
            th = th + tccm_pkg::PI_Q30;
            v.neg = 1'b1;
        end
        v.x  = tccm_pkg::GAIN_INV_Q30;
        v.y  = 32'sd0;
        v.th = th;
        return v;
    endfunction

    assign w_en    = !r_sd[L-1].vld || !i_stall;
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_x <= 16'd0;
            r_bias_y <= 16'd0;
            r_bias_z <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tccm_pkg::REG_BIAS_X: r_bias_x <= i_cfg_data;
                tccm_pkg::REG_BIAS_Y: r_bias_y <= i_cfg_data;
                tccm_pkg::REG_BIAS_Z: r_bias_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Side data: corrected axes are forced to zero on a failed read.
    always_comb begin
        n_sd0.vld = i_valid;
        n_sd0.err = i_read_failed;
        n_sd0.cx  = i_read_failed ? 16'sd0 : $signed(i_mag_x - r_bias_x);
        n_sd0.cy  = i_read_failed ? 16'sd0 : $signed(i_mag_y - r_bias_y);
        n_sd0.cz  = i_read_failed ? 16'sd0 : $signed(i_mag_z - r_bias_z);
    end

    genvar k;
    generate
        for (k = 0; k < L; k++) begin : g_side
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sd[k].vld <= 1'b0;
                end else if (w_en) begin
                    if (k == 0) begin
                        r_sd[k] <= n_sd0;
                    end else begin
                        r_sd[k] <= r_sd[(k == 0) ? 0 : k - 1];
                    end
                end
            end
        end
    endgenerate

    // Stage 0 scales the angles to Q30 radians; stage 1 reduces them.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_th_p <= 36'(i_pitch_angle) * tccm_pkg::ANG_SCALE;
            r_th_r <= 36'(i_roll_angle) * tccm_pkg::ANG_SCALE;
            r_rp   <= f_reduce(r_th_p);
            r_rr   <= f_reduce(r_th_r);
        end
    end

    assign w_p[0] = r_rp;
    assign w_r[0] = r_rr;

    generate
        for (k = 0; k < N; k++) begin : g_rot
            tccm_rot_stage #(.STEP(k)) u_rot_p (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_d   (w_p[k]),
                .o_q   (w_p[k+1])
            );
            tccm_rot_stage #(.STEP(k)) u_rot_r (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_d   (w_r[k]),
                .o_q   (w_r[k+1])
            );
        end
    endgenerate

    always_comb begin
        w_sp       = w_p[N].neg ? -w_p[N].y : w_p[N].y;
        w_cp       = w_p[N].neg ? -w_p[N].x : w_p[N].x;
        w_sr       = w_r[N].neg ? -w_r[N].y : w_r[N].y;
        w_cr       = w_r[N].neg ? -w_r[N].x : w_r[N].x;
        w_ssp_full = w_sr * w_sp;
        w_csr_full = w_cp * w_sr;
    end

    // Products against the corrected axes use the side data of the same stage as the sine and cosine registers.
    always_comb begin
        n_m0 = r_sd[N+2].cy * r_cr;
        n_m1 = r_sd[N+2].cx * r_ssp;
        n_m2 = r_sd[N+2].cz * r_csr;
        n_m3 = r_sd[N+2].cx * r_cp;
        n_m4 = r_sd[N+2].cz * r_sr;
    end

    always_comb begin
        n_v0.zero = (r_hx == 52'sd0) && (r_hy == 52'sd0);
        if (r_hx[51]) begin
            n_v0.x = -r_hx;
            n_v0.y = -r_hy;
            n_v0.z = r_hy[51] ? -tccm_pkg::PI_Q30 : tccm_pkg::PI_Q30;
        end else begin
            n_v0.x = r_hx;
            n_v0.y = r_hy;
            n_v0.z = 36'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ssp <= w_ssp_full[63:30];
            r_csr <= w_csr_full[63:30];
            r_cp  <= w_cp;
            r_sr  <= w_sr;
            r_cr  <= w_cr;
            r_m0  <= n_m0;
            r_m1  <= n_m1;
            r_m2  <= n_m2;
            r_m3  <= n_m3;
            r_m4  <= n_m4;
            r_hy  <= 52'(r_m0) + 52'(r_m1) - 52'(r_m2);
            r_hx  <= 52'(r_m3) + 52'(r_m4);
            r_v0  <= n_v0;
        end
    end

    assign w_v[0] = r_v0;

    generate
        for (k = 0; k < N; k++) begin : g_vec
            tccm_vec_stage #(.STEP(k)) u_vec (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_d   (w_v[k]),
                .o_q   (w_v[k+1])
            );
        end
    endgenerate

    tccm_head u_head (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_ang     (w_v[N].z),
        .i_zero    (w_v[N].zero),
        .o_heading (w_heading)
    );

    assign o_valid       = r_sd[L-1].vld;
    assign o_error_flag  = r_sd[L-1].err;
    assign o_corrected_x = r_sd[L-1].cx;
    assign o_corrected_y = r_sd[L-1].cy;
    assign o_corrected_z = r_sd[L-1].cz;
    assign o_heading     = r_sd[L-1].err ? 15'd0 : w_heading;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_flag |-> o_heading == 15'd0 && o_corrected_x == 16'sd0
                                    && o_corrected_y == 16'sd0 && o_corrected_z == 16'sd0)
        else $error("failed read produced nonzero result");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_heading <= 15'd23040)
        else $error("heading out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("transaction visible right after reset");

endmodule
